FILE: rtl/jcfk_pkg.sv
package jcfk_pkg;

  // Joint storage is fixed by the five-bit joint index.
  localparam int unsigned NODE_SLOTS = 32;
  localparam int unsigned NODE_W     = 5;
  localparam int unsigned PARENT_W   = 6;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned ROT_WORDS  = 9;

  // Input word layout: joint, parent_joint, then v0..v8, padded to bytes.
  localparam int unsigned IN_DATA_W  = 304;
  localparam int unsigned JOINT_LSB  = 0;
  localparam int unsigned PARENT_LSB = 5;
  localparam int unsigned V_LSB      = 11;
  localparam int unsigned OUT_DATA_W = 96;

  // Parent entry with bit 5 set marks a root joint.
  localparam logic [PARENT_W-1:0] NO_PARENT = 6'h3F;

  typedef enum logic [1:0] {
    FUNC_LOAD_JOINT = 2'd0,
    FUNC_LOAD_ROT   = 2'd1,
    FUNC_SET_ROOT   = 2'd2,
    FUNC_QUERY      = 2'd3
  } func_t;

  typedef logic [WORD_W-1:0]               word_t;
  typedef logic [2:0][WORD_W-1:0]          vec3_t;
  typedef logic [ROT_WORDS-1:0][WORD_W-1:0] rot_t;

endpackage

FILE: rtl/joint_chain_forward_kinematics.sv
// Forward kinematics over a joint chain. Load words (tuser 0, 1, 2) write a
// joint's parent and offset, a joint's 3x3 rotation, or the root position. A
// query word (tuser 3) walks from the named joint up through its ancestors,
// applying p = R*p + t at each, and returns the world position as one output
// word. All values are signed Q16.16; products are truncated toward minus
// infinity and sums wrap. One signed 32x32 multiplier is shared by all nine
// products of a level, at most JOINTS-1 ancestors are visited, and the input
// side is not ready while a query is in progress. A finished result waits in
// the output register, so load words are taken while it is unclaimed.
module joint_chain_forward_kinematics #(
  parameter int unsigned JOINTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: joint[4:0], parent_joint[10:5], v0..v8 (32 bits each
  // from bit 11), zero pad to 304 bits.
  input  logic [jcfk_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: func[1:0].
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64].
  output logic [jcfk_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned LVL_W = $clog2(JOINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_WAIT,
    S_INIT,
    S_CHECK,
    S_WAIT,
    S_MUL,
    S_OUT
  } state_t;

  state_t                              state;
  logic [jcfk_pkg::NODE_W-1:0]         cur;
  logic [LVL_W-1:0]                    levels;
  jcfk_pkg::vec3_t                     p;
  logic [1:0][jcfk_pkg::WORD_W-1:0]    np;
  jcfk_pkg::word_t                     acc;
  logic signed [2*jcfk_pkg::WORD_W-1:0] prod;

  // Multiplier issue and accumulate tags.
  logic                                iss_vld;
  logic [3:0]                          iss_idx;
  logic [1:0]                          iss_row;
  logic [1:0]                          iss_col;
  logic                                tag_vld;
  logic [1:0]                          tag_row;
  logic [1:0]                          tag_col;

  // Storage.
  logic [jcfk_pkg::PARENT_W-1:0]       parent_tab [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::vec3_t                     off_mem [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::rot_t                      rot_mem [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::vec3_t                     root_pos;
  jcfk_pkg::vec3_t                     off_rd;
  jcfk_pkg::rot_t                      rot_rd;

  // Input field decode.
  logic                                in_acc;
  jcfk_pkg::func_t                     in_func;
  logic [jcfk_pkg::NODE_W-1:0]         in_joint;
  logic [jcfk_pkg::PARENT_W-1:0]       in_parent;
  jcfk_pkg::rot_t                      in_v;

  logic                                cur_has_par;
  logic [jcfk_pkg::PARENT_W-1:0]       cur_parent;
  jcfk_pkg::vec3_t                     tsel;
  jcfk_pkg::word_t                     prod_sh;
  jcfk_pkg::word_t                     row_sum;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_func       = jcfk_pkg::func_t'(s_axis_tuser);
  assign in_joint      = s_axis_tdata[jcfk_pkg::JOINT_LSB +: jcfk_pkg::NODE_W];
  assign in_parent     = s_axis_tdata[jcfk_pkg::PARENT_LSB +: jcfk_pkg::PARENT_W];

  always_comb begin
    for (int k = 0; k < jcfk_pkg::ROT_WORDS; k++) begin
      in_v[k] = s_axis_tdata[jcfk_pkg::V_LSB + k*jcfk_pkg::WORD_W +: jcfk_pkg::WORD_W];
    end
  end

  // Parent lookup of the joint being walked and its own translation.
  assign cur_parent  = parent_tab[cur];
  assign cur_has_par = ~cur_parent[jcfk_pkg::PARENT_W-1];
  assign tsel        = cur_has_par ? off_rd : root_pos;

  // Truncated Q16.16 product and the row sum with translation.
  assign prod_sh = prod[jcfk_pkg::FRAC_W +: jcfk_pkg::WORD_W];
  assign row_sum = acc + prod_sh + tsel[tag_row];

  // Parent table and root position reset to root and zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jcfk_pkg::NODE_SLOTS; i++) begin
        parent_tab[i] <= jcfk_pkg::NO_PARENT;
      end
      root_pos <= '0;
    end else if (in_acc) begin
      if (in_func == jcfk_pkg::FUNC_LOAD_JOINT) begin
        parent_tab[in_joint] <= in_parent;
      end
      if (in_func == jcfk_pkg::FUNC_SET_ROOT) begin
        root_pos <= in_v[2:0];
      end
    end
  end

  // Offset and rotation memories, one row per joint, registered read at cur.
  always_ff @(posedge clk) begin
    if (in_acc && (in_func == jcfk_pkg::FUNC_LOAD_JOINT)) begin
      off_mem[in_joint] <= in_v[2:0];
    end
    if (in_acc && (in_func == jcfk_pkg::FUNC_LOAD_ROT)) begin
      rot_mem[in_joint] <= in_v;
    end
    off_rd <= off_mem[cur];
    rot_rd <= rot_mem[cur];
  end

  // Query sequencer around the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      iss_vld       <= 1'b0;
      tag_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output state sets valid itself when it loads a new word.
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_func == jcfk_pkg::FUNC_QUERY)) begin
            cur    <= in_joint;
            levels <= LVL_W'(1);
            state  <= S_INIT_WAIT;
          end
        end

        S_INIT_WAIT: begin
          state <= S_INIT;
        end

        S_INIT: begin
          p     <= tsel;
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (cur_has_par && (levels < LVL_W'(JOINTS))) begin
            cur    <= cur_parent[jcfk_pkg::NODE_W-1:0];
            levels <= levels + LVL_W'(1);
            state  <= S_WAIT;
          end else begin
            state <= S_OUT;
          end
        end

        S_WAIT: begin
          iss_vld <= 1'b1;
          iss_idx <= '0;
          iss_row <= '0;
          iss_col <= '0;
          tag_vld <= 1'b0;
          state   <= S_MUL;
        end

        S_MUL: begin
          // Issue one product per cycle, row by row.
          tag_vld <= iss_vld;
          if (iss_vld) begin
            prod    <= $signed(rot_rd[iss_idx]) * $signed(p[iss_col]);
            tag_row <= iss_row;
            tag_col <= iss_col;
            iss_idx <= iss_idx + 4'd1;
            if (iss_idx == 4'd8) begin
              iss_vld <= 1'b0;
            end
            if (iss_col == 2'd2) begin
              iss_col <= '0;
              iss_row <= iss_row + 2'd1;
            end else begin
              iss_col <= iss_col + 2'd1;
            end
          end
          // Accumulate the product issued in the previous cycle.
          if (tag_vld) begin
            unique case (tag_col)
              2'd0: acc <= prod_sh;
              2'd1: acc <= acc + prod_sh;
              default: begin
                if (tag_row == 2'd2) begin
                  p     <= {row_sum, np[1], np[0]};
                  state <= S_CHECK;
                end else begin
                  np[tag_row[0]] <= row_sum;
                end
              end
            endcase
          end
        end

        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= p;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/jcfk_checker.sv
module jcfk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [1:0]                      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [jcfk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic query_acc;
  logic load_acc;

  assign query_acc = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == jcfk_pkg::FUNC_QUERY);
  assign load_acc  = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser != jcfk_pkg::FUNC_QUERY);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Reset leaves no result pending.
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A query occupies the block; no other word is taken right after it.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> !s_axis_tready)
    else $error("input ready right after a query");

  // Load words never produce a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    load_acc && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result word after a load");

endmodule

bind joint_chain_forward_kinematics jcfk_checker u_jcfk_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WALK_LIMIT  = 32;
  localparam int unsigned TOTAL_WORDS = 1900;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam longint unsigned LIMIT_NS = 64'd20_000_000;
  localparam jcfk_pkg::word_t ONE = 32'h0001_0000;
  // Lowest negative parent code; like -1 it marks a joint with no parent.
  localparam logic [jcfk_pkg::PARENT_W-1:0] ROOT_MARK_LOW = 6'h20;

  // One input word as the skeleton sees it.
  typedef struct packed {
    jcfk_pkg::func_t               func;
    logic [jcfk_pkg::NODE_W-1:0]   joint;
    logic [jcfk_pkg::PARENT_W-1:0] parent;
    jcfk_pkg::rot_t                v;
  } fk_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // Fields from bit 0: joint, parent_joint, v0..v8, zero pad.
  logic [jcfk_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // Fields from bit 0: func.
  logic [1:0]                      s_axis_tuser = jcfk_pkg::FUNC_LOAD_JOINT;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  // Fields from bit 0: pos_x, pos_y, pos_z.
  logic [jcfk_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the skeleton and pose.
  logic [jcfk_pkg::PARENT_W-1:0] parent_tbl [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::vec3_t               offset_tbl [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::rot_t                rot_tbl    [jcfk_pkg::NODE_SLOTS];
  bit                            rot_loaded [jcfk_pkg::NODE_SLOTS];
  jcfk_pkg::vec3_t               root_pos;

  jcfk_pkg::vec3_t world_pos_due [$];
  int unsigned     words_sent = 0;
  int unsigned     mismatches = 0;
  bit              no_idle = 1'b0;
  int unsigned     ready_hold = 0;

  joint_chain_forward_kinematics #(.JOINTS(WALK_LIMIT)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Signed Q16.16 product, low bits dropped (rounds toward minus infinity).
  function automatic jcfk_pkg::word_t fixed_mul(jcfk_pkg::word_t a, jcfk_pkg::word_t b);
    longint prod;
    prod = longint'(signed'(a)) * longint'(signed'(b));
    return jcfk_pkg::word_t'(prod >>> jcfk_pkg::FRAC_W);
  endfunction

  // A joint's own translation: its offset, or the root position if it has no parent.
  function automatic jcfk_pkg::vec3_t joint_translation(logic [jcfk_pkg::NODE_W-1:0] j);
    return parent_tbl[j][jcfk_pkg::PARENT_W-1] ? root_pos : offset_tbl[j];
  endfunction

  // Walk up the chain applying p = R*p + t for each ancestor.
  function automatic jcfk_pkg::vec3_t world_position(logic [jcfk_pkg::NODE_W-1:0] j);
    jcfk_pkg::vec3_t             p;
    jcfk_pkg::vec3_t             t;
    jcfk_pkg::vec3_t             np;
    jcfk_pkg::rot_t              r;
    logic [jcfk_pkg::NODE_W-1:0] cur;
    int unsigned                 depth;
    cur = j;
    p = joint_translation(cur);
    depth = 1;
    while (!parent_tbl[cur][jcfk_pkg::PARENT_W-1] && depth < WALK_LIMIT) begin
      cur = parent_tbl[cur][jcfk_pkg::NODE_W-1:0];
      r = rot_tbl[cur];
      t = joint_translation(cur);
      for (int k = 0; k < 3; k++) begin
        np[k] = fixed_mul(r[3*k], p[0]) + fixed_mul(r[3*k+1], p[1])
              + fixed_mul(r[3*k+2], p[2]) + t[k];
      end
      p = np;
      depth++;
    end
    return p;
  endfunction

  // True when every rotation the walk from j reads has been loaded.
  function automatic bit walk_defined(input logic [jcfk_pkg::NODE_W-1:0] j,
                                      output logic [jcfk_pkg::NODE_W-1:0] missing);
    logic [jcfk_pkg::NODE_W-1:0] cur;
    int unsigned                 depth;
    cur = j;
    depth = 1;
    missing = '0;
    while (!parent_tbl[cur][jcfk_pkg::PARENT_W-1] && depth < WALK_LIMIT) begin
      cur = parent_tbl[cur][jcfk_pkg::NODE_W-1:0];
      if (!rot_loaded[cur]) begin
        missing = cur;
        return 1'b0;
      end
      depth++;
    end
    return 1'b1;
  endfunction

  // Mostly no gap, sometimes a short one, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic jcfk_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return ONE;
        endcase
      end
      default: return jcfk_pkg::word_t'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic jcfk_pkg::rot_t rand_values();
    jcfk_pkg::rot_t v;
    for (int k = 0; k < jcfk_pkg::ROT_WORDS; k++) v[k] = rand_word();
    return v;
  endfunction

  // Half the matrices stay within +-1.0 so chains do not just wrap.
  function automatic jcfk_pkg::rot_t rand_rotation();
    jcfk_pkg::rot_t v;
    if ($urandom_range(0, 1) == 0) return rand_values();
    for (int k = 0; k < jcfk_pkg::ROT_WORDS; k++) begin
      v[k] = jcfk_pkg::word_t'($urandom_range(0, 32'h0002_0000)) - ONE;
    end
    return v;
  endfunction

  function automatic logic [jcfk_pkg::PARENT_W-1:0] pick_parent(
      logic [jcfk_pkg::NODE_W-1:0] j);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && j != 0) return {1'b0, j - 5'd1};
    if (roll < 70 && j != 0) return {1'b0, 5'($urandom_range(0, j - 1))};
    if (roll < 80) return jcfk_pkg::NO_PARENT;
    if (roll < 84) return {1'b1, 5'($urandom())};
    if (roll < 90) return {1'b0, j};
    return {1'b0, 5'($urandom())};
  endfunction

  function automatic fk_word_t make_word(jcfk_pkg::func_t f,
                                         logic [jcfk_pkg::NODE_W-1:0] j,
                                         logic [jcfk_pkg::PARENT_W-1:0] par,
                                         jcfk_pkg::rot_t v);
    fk_word_t w;
    w.func = f;
    w.joint = j;
    w.parent = par;
    w.v = v;
    return w;
  endfunction

  // Update the shadow state for an accepted word; a query yields one position.
  task automatic apply_word(input fk_word_t w);
    case (w.func)
      jcfk_pkg::FUNC_LOAD_JOINT: begin
        parent_tbl[w.joint] = w.parent;
        offset_tbl[w.joint] = w.v[2:0];
      end
      jcfk_pkg::FUNC_LOAD_ROT: begin
        rot_tbl[w.joint] = w.v;
        rot_loaded[w.joint] = 1'b1;
      end
      jcfk_pkg::FUNC_SET_ROOT: root_pos = w.v[2:0];
      default: world_pos_due.push_back(world_position(w.joint));
    endcase
  endtask

  // Present one word at the falling edge and hold it until it is taken.
  task automatic send_word(input fk_word_t w);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.func;
    s_axis_tdata  <= jcfk_pkg::IN_DATA_W'({w.v, w.parent, w.joint});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_word(w);
    words_sent++;
  endtask

  // Query a joint, first loading any rotation its walk would read unset.
  task automatic query_joint(input logic [jcfk_pkg::NODE_W-1:0] j);
    logic [jcfk_pkg::NODE_W-1:0] missing;
    while (!walk_defined(j, missing)) begin
      send_word(make_word(jcfk_pkg::FUNC_LOAD_ROT, missing, 6'($urandom()),
                          rand_rotation()));
    end
    send_word(make_word(jcfk_pkg::FUNC_QUERY, j, 6'($urandom()), rand_values()));
  endtask

  task automatic load_joint(input logic [jcfk_pkg::NODE_W-1:0] j,
                            input logic [jcfk_pkg::PARENT_W-1:0] par,
                            input jcfk_pkg::rot_t v);
    send_word(make_word(jcfk_pkg::FUNC_LOAD_JOINT, j, par, v));
  endtask

  task automatic load_rotation(input logic [jcfk_pkg::NODE_W-1:0] j,
                               input jcfk_pkg::rot_t v);
    send_word(make_word(jcfk_pkg::FUNC_LOAD_ROT, j, 6'($urandom()), v));
  endtask

  task automatic set_root(input logic [jcfk_pkg::NODE_W-1:0] j,
                          input jcfk_pkg::rot_t v);
    send_word(make_word(jcfk_pkg::FUNC_SET_ROOT, j, 6'($urandom()), v));
  endtask

  // After reset every joint is a root joint at the zero root position.
  task automatic test_reset_state();
    query_joint(5'd0);
    query_joint(5'd31);
  endtask

  // A two-level chain under a root set near the edges of the range.
  task automatic test_short_chain();
    jcfk_pkg::rot_t v;
    v = rand_values();
    v[2:0] = {32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_8000};
    set_root(5'($urandom()), v);
    // Quarter turn about z, with a negative entry.
    load_rotation(5'd0, {ONE, 32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, -ONE, 32'h0});
    load_joint(5'd0, jcfk_pkg::NO_PARENT, rand_values());
    v = rand_values();
    v[2:0] = {32'h8000_0000, 32'hFFFF_FFFF, 32'h0002_0000};
    load_joint(5'd1, 6'd0, v);
    query_joint(5'd1);
    query_joint(5'd0);
  endtask

  // Extreme matrix entries and offsets, including products that truncate downward.
  task automatic test_extremes();
    jcfk_pkg::rot_t v;
    load_rotation(5'd2, {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    v = rand_values();
    v[2:0] = {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    load_joint(5'd7, 6'd2, v);
    query_joint(5'd7);
    load_rotation(5'd2, {jcfk_pkg::ROT_WORDS{32'hFFFF_FFFF}});
    query_joint(5'd7);
  endtask

  // A joint that is its own parent repeats until the walk bound.
  task automatic test_self_parent();
    load_rotation(5'd3, rand_rotation());
    load_joint(5'd3, 6'd3, rand_values());
    query_joint(5'd3);
  endtask

  // Two joints that name each other are also cut at the walk bound.
  task automatic test_parent_loop();
    load_rotation(5'd4, rand_rotation());
    load_rotation(5'd5, rand_rotation());
    load_joint(5'd4, 6'd5, rand_values());
    load_joint(5'd5, 6'd4, rand_values());
    query_joint(5'd4);
  endtask

  // Any negative parent code means a root joint; setting the root ignores joint.
  task automatic test_root_markers();
    load_joint(5'd6, ROOT_MARK_LOW, rand_values());
    set_root(5'd31, rand_values());
    query_joint(5'd6);
  endtask

  // Mostly skeleton building and queries, with stretches run without idling.
  task automatic test_random_traffic();
    int unsigned                 roll;
    logic [jcfk_pkg::NODE_W-1:0] j;
    while (words_sent < TOTAL_WORDS) begin
      no_idle = ((words_sent / 250) % 4) == 3;
      roll = $urandom_range(0, 99);
      j = 5'($urandom());
      if (roll < 30) load_joint(j, pick_parent(j), rand_values());
      else if (roll < 45) load_rotation(j, rand_rotation());
      else if (roll < 50) set_root(j, rand_values());
      else query_joint(j);
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(input string name, input jcfk_pkg::word_t want,
                             input jcfk_pkg::word_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s mismatch: expected %h, got %h", name, want, got);
      end
    end
  endtask

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      ready_hold = idle_len();
    end
  end

  // Compare each result word with the oldest pending position.
  always @(posedge clk) begin : check_result
    jcfk_pkg::vec3_t want;
    jcfk_pkg::vec3_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = jcfk_pkg::vec3_t'(m_axis_tdata);
      if (world_pos_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word with no query outstanding: %h", m_axis_tdata);
        end
      end else begin
        want = world_pos_due.pop_front();
        check_field("pos_x", want[0], got[0]);
        check_field("pos_y", want[1], got[1]);
        check_field("pos_z", want[2], got[2]);
      end
    end
  end

  initial begin
    for (int k = 0; k < jcfk_pkg::NODE_SLOTS; k++) begin
      parent_tbl[k] = jcfk_pkg::NO_PARENT;
      offset_tbl[k] = '0;
      rot_tbl[k] = '0;
      rot_loaded[k] = 1'b0;
    end
    root_pos = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_short_chain();
    test_extremes();
    test_self_parent();
    test_parent_loop();
    test_root_markers();
    test_random_traffic();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (world_pos_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

endmodule
